>>> rtl/core/crx_pkg.sv
`default_nettype none

package crx_pkg;

  // Number of element lanes and the largest element count the block honors.
  localparam int NUM_ELEM     = 4;
  localparam int MAX_ELEMENTS = 4;
  localparam int NUM_PERMS    = 24;

  // Divider pipeline: quotient bits resolved per stage and stage count.
  localparam int QUO_W              = 32;
  localparam int DIV_BITS_PER_STAGE = 4;
  localparam int DIV_STAGES         = QUO_W / DIV_BITS_PER_STAGE;

  // One adjustment step: product stage, divider stages, compare stage.
  localparam int STEP_LAT = DIV_STAGES + 2;
  localparam int NUM_STEPS = NUM_ELEM - 1;

  // Weight delay line length, and total latency from start to strobe.
  localparam int W_DLY = NUM_STEPS * STEP_LAT - 1;
  localparam int RED_LAT = 3;
  localparam int LAT = 2 + NUM_STEPS * STEP_LAT + RED_LAT;

  localparam int CFG_W = 48;

  typedef logic [15:0] q16_t;
  typedef logic [31:0] wt_t;
  typedef logic [33:0] sum_t;
  typedef logic [1:0]  elem_idx_t;

  typedef q16_t [NUM_ELEM-1:0] q16vec_t;
  typedef wt_t  [NUM_ELEM-1:0] wvec_t;

  // Input word: one pixel's intensities.
  typedef struct packed {
    q16_t intensity_a;
    q16_t intensity_b;
    q16_t intensity_c;
    q16_t intensity_d;
  } item_t;

  // Output word.
  typedef struct packed {
    sum_t compound_value;
    logic any_valid;
  } result_t;

  // State of one ordering as it moves from step to step.
  typedef struct packed {
    wt_t  adj;
    sum_t sum;
    logic fail;
  } lane_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_COUNT = 3'd0,
    CFG_COEF0 = 3'd1,
    CFG_COEF1 = 3'd2,
    CFG_COEF2 = 3'd3,
    CFG_COEF3 = 3'd4
  } cfg_idx_e;

  // All orderings of four elements; element j of an ordering sits at bits 2j+1:2j.
  localparam logic [7:0] PERMS [NUM_PERMS] = '{
    8'b11100100, 8'b10110100, 8'b11011000, 8'b01111000,
    8'b10011100, 8'b01101100, 8'b11100001, 8'b10110001,
    8'b11001001, 8'b00111001, 8'b10001101, 8'b00101101,
    8'b11010010, 8'b01110010, 8'b11000110, 8'b00110110,
    8'b01001110, 8'b00011110, 8'b10010011, 8'b01100011,
    8'b10000111, 8'b00100111, 8'b01001011, 8'b00011011
  };

endpackage

`default_nettype wire

>>> rtl/core/crx_weight.sv
`default_nettype none

module crx_weight (
  input  wire logic             clk_i,
  input  wire crx_pkg::item_t   item_i,
  input  wire crx_pkg::q16vec_t max_i,
  input  wire crx_pkg::q16vec_t gp_i,
  output crx_pkg::wvec_t        w_o
);
  import crx_pkg::*;

  q16vec_t inten;
  wt_t [NUM_ELEM-1:0] prod_q;
  wvec_t w_q;

  assign inten[0] = item_i.intensity_a;
  assign inten[1] = item_i.intensity_b;
  assign inten[2] = item_i.intensity_c;
  assign inten[3] = item_i.intensity_d;

  // First product: intensity times max intensity.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_ELEM; k++) begin
      prod_q[k] <= 32'(inten[k]) * 32'(max_i[k]);
    end
  end

  // Second product with the global percentage, dropping the Q0.16 fraction.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_ELEM; k++) begin
      w_q[k] <= 32'((48'(prod_q[k]) * 48'(gp_i[k])) >> 16);
    end
  end

  assign w_o = w_q;

endmodule

`default_nettype wire

>>> rtl/core/crx_step.sv
`default_nettype none

module crx_step (
  input  wire logic           clk_i,
  input  wire crx_pkg::lane_t lane_i,
  input  wire crx_pkg::q16_t  perc_prev_i,
  input  wire crx_pkg::q16_t  perc_this_i,
  input  wire crx_pkg::wt_t   w_this_i,
  input  wire logic           active_i,
  output crx_pkg::lane_t      lane_o
);
  import crx_pkg::*;

  typedef struct packed {
    q16_t rem;
    wt_t  num;
    q16_t dvs;
    sum_t sum;
    logic fail;
    logic ovf;
    logic active;
  } div_t;

  logic [47:0] prod_q;
  q16_t        dvs_q;
  sum_t        sum_m_q;
  logic        fail_m_q;
  logic        active_m_q;
  div_t        div_q [DIV_STAGES];
  div_t        div_init;
  lane_t       lane_q;

  // A few restoring division steps; the quotient shifts into num.
  function automatic div_t div_steps(div_t s);
    div_t        r;
    logic [16:0] t;
    r = s;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      t = {r.rem, r.num[QUO_W-1]};
      if (t >= {1'b0, r.dvs}) begin
        r.rem = 16'(t - {1'b0, r.dvs});
        r.num = {r.num[QUO_W-2:0], 1'b1};
      end else begin
        r.rem = t[15:0];
        r.num = {r.num[QUO_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Scale the previous adjusted value by this element's percentage.
  always_ff @(posedge clk_i) begin
    prod_q     <= 48'(lane_i.adj) * 48'(perc_this_i);
    dvs_q      <= perc_prev_i;
    sum_m_q    <= lane_i.sum;
    fail_m_q   <= lane_i.fail | (active_i & (perc_prev_i == '0));
    active_m_q <= active_i;
  end

  // A high half at or above the divisor means a quotient beyond any weight.
  always_comb begin
    div_init.rem    = prod_q[47:32];
    div_init.num    = prod_q[31:0];
    div_init.dvs    = dvs_q;
    div_init.sum    = sum_m_q;
    div_init.fail   = fail_m_q;
    div_init.ovf    = (prod_q[47:32] >= dvs_q);
    div_init.active = active_m_q;
  end

  // Divider pipeline.
  always_ff @(posedge clk_i) begin
    div_q[0] <= div_steps(div_init);
    for (int s = 1; s < DIV_STAGES; s++) begin
      div_q[s] <= div_steps(div_q[s-1]);
    end
  end

  // Check against the weight and accumulate; four weights never exceed 34 bits.
  always_ff @(posedge clk_i) begin
    lane_q.adj  <= div_q[DIV_STAGES-1].num;
    lane_q.fail <= div_q[DIV_STAGES-1].fail |
                   (div_q[DIV_STAGES-1].active &
                    (div_q[DIV_STAGES-1].ovf | (div_q[DIV_STAGES-1].num > w_this_i)));
    lane_q.sum  <= div_q[DIV_STAGES-1].active ?
                   div_q[DIV_STAGES-1].sum + {2'b00, div_q[DIV_STAGES-1].num} :
                   div_q[DIV_STAGES-1].sum;
  end

  assign lane_o = lane_q;

endmodule

`default_nettype wire

>>> rtl/core/crx_reduce.sv
`default_nettype none

module crx_reduce (
  input  wire logic                           clk_i,
  input  wire crx_pkg::sum_t                  sum_i [crx_pkg::NUM_PERMS],
  input  wire logic [crx_pkg::NUM_PERMS-1:0]  ok_i,
  output crx_pkg::result_t                    res_o
);
  import crx_pkg::*;

  localparam int G1 = NUM_PERMS / 4;
  localparam int G2 = G1 / 3;

  sum_t       best1_q [G1];
  logic [G1-1:0] any1_q;
  sum_t       best2_q [G2];
  logic [G2-1:0] any2_q;
  result_t    res_q;

  // Groups of four orderings; an ordering that failed counts as zero.
  always_ff @(posedge clk_i) begin
    for (int g = 0; g < G1; g++) begin
      sum_t b;
      logic a;
      b = '0;
      a = 1'b0;
      for (int i = 0; i < 4; i++) begin
        if (ok_i[4*g+i]) begin
          a = 1'b1;
          if (sum_i[4*g+i] > b) begin
            b = sum_i[4*g+i];
          end
        end
      end
      best1_q[g] <= b;
      any1_q[g]  <= a;
    end
  end

  // Groups of three partial maxima.
  always_ff @(posedge clk_i) begin
    for (int g = 0; g < G2; g++) begin
      sum_t b;
      b = '0;
      for (int i = 0; i < 3; i++) begin
        if (best1_q[3*g+i] > b) begin
          b = best1_q[3*g+i];
        end
      end
      best2_q[g] <= b;
      any2_q[g]  <= |any1_q[3*g +: 3];
    end
  end

  // Final maximum into the output register.
  always_ff @(posedge clk_i) begin
    res_q.compound_value <= (best2_q[1] > best2_q[0]) ? best2_q[1] : best2_q[0];
    res_q.any_valid      <= |any2_q;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

>>> rtl/core/compound_from_element_ratios_unit.sv
`default_nettype none
// Channel   Direction  Handshake             Word
// item      in         start_i, busy_o       item_i (four Q0.16 intensities)
// result    out        res_valid_o strobe    res_o (compound_value, any_valid)
// config    in         cfg_we_i, cfg_idx_i   cfg_data_i (48 bits)
//
// One pixel enters every cycle; busy_o stays low.
// Each result passes two weight multiply stages, three adjustment steps
// (product, eight divider stages of four quotient bits, compare), and a
// three-stage maximum tree.
// Reset clears the valid pipeline and restores the configuration registers.
// The receiver takes every strobe, so the pipeline never stalls.

module compound_from_element_ratios_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire crx_pkg::item_t              item_i,
  output logic                             res_valid_o,
  output crx_pkg::result_t                 res_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [2:0]                  cfg_idx_i,
  input  wire logic [crx_pkg::CFG_W-1:0]   cfg_data_i
);
  import crx_pkg::*;

  logic [2:0]       cnt_q;
  logic [CFG_W-1:0] coef_q [NUM_ELEM];
  logic [2:0]       n_eff;
  q16vec_t          max_v, gp_v, perc_v;
  wvec_t            w_q;
  wvec_t            w_dly_q [1:W_DLY];
  logic [LAT-1:0]   vld_q;
  lane_t            lane [NUM_PERMS][NUM_ELEM];
  sum_t             lane_sum [NUM_PERMS];
  logic [NUM_PERMS-1:0] cand, ok;

  assign busy_o = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd1;
      for (int k = 0; k < NUM_ELEM; k++) begin
        coef_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COUNT: cnt_q     <= cfg_data_i[2:0];
        CFG_COEF0: coef_q[0] <= cfg_data_i;
        CFG_COEF1: coef_q[1] <= cfg_data_i;
        CFG_COEF2: coef_q[2] <= cfg_data_i;
        CFG_COEF3: coef_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Active element count, clamped to the supported range.
  always_comb begin
    if (cnt_q == 3'd0) begin
      n_eff = 3'd1;
    end else if (cnt_q > 3'(MAX_ELEMENTS)) begin
      n_eff = 3'(MAX_ELEMENTS);
    end else begin
      n_eff = cnt_q;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_ELEM; k++) begin
      max_v[k]  = coef_q[k][47:32];
      gp_v[k]   = coef_q[k][31:16];
      perc_v[k] = coef_q[k][15:0];
    end
  end

  // Valid bits travel alongside the data pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i & ~busy_o};
    end
  end

  crx_weight u_weight (
    .clk_i  (clk_i),
    .item_i (item_i),
    .max_i  (max_v),
    .gp_i   (gp_v),
    .w_o    (w_q)
  );

  // Weights delayed to meet each step's compare stage.
  always_ff @(posedge clk_i) begin
    w_dly_q[1] <= w_q;
    for (int i = 2; i <= W_DLY; i++) begin
      w_dly_q[i] <= w_dly_q[i-1];
    end
  end

  // One chain of adjustment steps per ordering.
  for (genvar l = 0; l < NUM_PERMS; l++) begin : g_lane
    localparam elem_idx_t E0 = PERMS[l][1:0];
    assign lane[l][0].adj  = w_q[E0];
    assign lane[l][0].sum  = {2'b00, w_q[E0]};
    assign lane[l][0].fail = 1'b0;

    for (genvar j = 1; j < NUM_ELEM; j++) begin : g_step
      localparam elem_idx_t EP = PERMS[l][2*j-2 +: 2];
      localparam elem_idx_t EC = PERMS[l][2*j +: 2];
      crx_step u_step (
        .clk_i       (clk_i),
        .lane_i      (lane[l][j-1]),
        .perc_prev_i (perc_v[EP]),
        .perc_this_i (perc_v[EC]),
        .w_this_i    (w_dly_q[STEP_LAT*j-1][EC]),
        .active_i    (3'(j) < n_eff),
        .lane_o      (lane[l][j])
      );
    end

    // An ordering counts when its active prefix uses only active elements.
    always_comb begin
      cand[l] = 1'b1;
      for (int j = 0; j < NUM_ELEM; j++) begin
        if ((3'(j) < n_eff) && ({1'b0, PERMS[l][2*j +: 2]} >= n_eff)) begin
          cand[l] = 1'b0;
        end
      end
    end

    assign lane_sum[l] = lane[l][NUM_ELEM-1].sum;
    assign ok[l]       = cand[l] & ~lane[l][NUM_ELEM-1].fail;
  end

  crx_reduce u_reduce (
    .clk_i (clk_i),
    .sum_i (lane_sum),
    .ok_i  (ok),
    .res_o (res_o)
  );

  assign res_valid_o = vld_q[LAT-1];

`ifndef ASSERT_OFF
  a_strobe_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start_i & ~busy_o, LAT))
    else $error("result strobe without a matching start");

  a_none_valid_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.any_valid) |-> (res_o.compound_value == '0))
    else $error("nonzero value with no valid ordering");

  a_single_always_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (n_eff == 3'd1)) |-> res_o.any_valid)
    else $error("single element ordering reported invalid");
`endif

endmodule

`default_nettype wire

>>> verif/compound_from_element_ratios_unit_tb.sv
`timescale 1ns / 1ps

module compound_from_element_ratios_unit_tb;
  import crx_pkg::*;

  localparam int PIPE_LAT   = 35;
  localparam int CYCLE_LIMIT = 400000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             busy_o;
  item_t            item_i = '0;
  logic             res_valid_o;
  result_t          res_o;
  logic             cfg_we_i = 1'b0;
  logic [2:0]       cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  compound_from_element_ratios_unit dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .res_valid_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // Testbench copy of the configuration.
  logic [2:0]       count_q;
  logic [CFG_W-1:0] coef_q [4];

  item_t   pixel_q[$];
  result_t compound_q[$];
  int      idle_pct = 0;
  int      errors = 0;
  int      checked = 0;
  int      pixels_sent = 0;
  longint  cycles = 0;

  // Weighted value for one element lane.
  function automatic logic [63:0] weight(logic [15:0] inten, logic [CFG_W-1:0] c);
    logic [63:0] p;
    p = {48'd0, inten} * {48'd0, c[47:32]};
    p = p * {48'd0, c[31:16]};
    return p >> 16;
  endfunction

  // Best valid sum over every ordering of the active elements.
  function automatic result_t compound_of(item_t px);
    logic [63:0] w [4];
    logic [15:0] intens [4];
    int n;
    int ord [4];
    logic [63:0] adj, sum, best, dv;
    logic ok, any;
    result_t r;
    intens[0] = px.intensity_a;
    intens[1] = px.intensity_b;
    intens[2] = px.intensity_c;
    intens[3] = px.intensity_d;
    for (int k = 0; k < 4; k++) w[k] = weight(intens[k], coef_q[k]);
    n = count_q;
    if (n < 1) n = 1;
    if (n > MAX_ELEMENTS) n = MAX_ELEMENTS;
    best = 0;
    any = 1'b0;
    for (int a = 0; a < n; a++)
      for (int b = 0; b < (n > 1 ? n : 1); b++)
        for (int c = 0; c < (n > 2 ? n : 1); c++)
          for (int d = 0; d < (n > 3 ? n : 1); d++) begin
            ord[0] = a; ord[1] = b; ord[2] = c; ord[3] = d;
            ok = 1'b1;
            for (int i = 0; i < n; i++)
              for (int j = 0; j < i; j++)
                if (ord[i] == ord[j]) ok = 1'b0;
            if (!ok) continue;
            adj = w[a];
            sum = adj;
            for (int i = 1; i < n; i++) begin
              if (ok) begin
                dv = {48'd0, coef_q[ord[i-1]][15:0]};
                if (dv == 0) begin
                  ok = 1'b0;
                end else begin
                  adj = (adj * {48'd0, coef_q[ord[i]][15:0]}) / dv;
                  if (adj > w[ord[i]]) ok = 1'b0;
                  else begin
                    sum = sum + adj;
                    if (sum > 64'h3FFFFFFFF) sum = 64'h3FFFFFFFF;
                  end
                end
              end
            end
            if (ok) begin
              any = 1'b1;
              if (sum > best) best = sum;
            end
          end
    r.compound_value = best[33:0];
    r.any_valid = any;
    return r;
  endfunction

  // Driver: one pixel word per accepted start.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (start_i && !busy_o) begin
      compound_q.insert(compound_q.size(), compound_of(item_i));
      pixels_sent <= pixels_sent + 1;
    end
    if (rst_ni && pixel_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start_i <= 1'b1;
      item_i <= pixel_q.pop_front();
    end else begin
      start_i <= 1'b0;
    end
  end

  // Monitor: compare each strobed result with the oldest expectation.
  always @(posedge clk_i) begin
    if (res_valid_o) begin
      if (compound_q.size() == 0) begin
        $error("result with nothing expected: %h", res_o);
        errors++;
      end else begin
        result_t e;
        e = compound_q.pop_front();
        checked++;
        if (res_o.compound_value !== e.compound_value) begin
          $error("compound_value expected %h actual %h", e.compound_value,
                 res_o.compound_value);
          errors++;
        end
        if (res_o.any_valid !== e.any_valid) begin
          $error("any_valid expected %b actual %b", e.any_valid, res_o.any_valid);
          errors++;
        end
      end
    end
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("compound_from_element_ratios_unit test failed");
      $finish;
    end
  end

  // Append one pixel word to the pending queue.
  task automatic queue_pixel(item_t p);
    pixel_q.insert(pixel_q.size(), p);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == CFG_COUNT) count_q = val[2:0];
    else coef_q[idx - CFG_COEF0] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every expected word has come, plus pipeline drain.
  task automatic drain();
    while (pixel_q.size() > 0 || start_i || compound_q.size() > 0) @(posedge clk_i);
    repeat (PIPE_LAT + 5) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rnd16();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rnd_coef(int mode);
    logic [15:0] mx, gp, pc;
    mx = (mode == 0) ? 16'hFFFF : rnd16();
    gp = (mode == 0) ? 16'hFFFF : rnd16();
    pc = rnd16();
    // Mostly nonzero percentages so that orderings can pass.
    if (mode == 2 && pc == 0) pc = 16'h1000;
    return {mx, gp, pc};
  endfunction

  function automatic item_t rnd_pixel();
    item_t p;
    p.intensity_a = rnd16();
    p.intensity_b = rnd16();
    p.intensity_c = rnd16();
    p.intensity_d = rnd16();
    return p;
  endfunction

  // Random pixels whose intensities each lie within ten percent of one shared base.
  function automatic item_t ratio_pixel();
    item_t p;
    logic [15:0] v [4];
    logic [15:0] base;
    base = 16'($urandom_range(1, 65535));
    for (int k = 0; k < 4; k++)
      v[k] = 16'(({16'd0, base} * ($urandom_range(90, 110))) / 100 > 65535 ?
             65535 : ({16'd0, base} * ($urandom_range(90, 110))) / 100);
    p.intensity_a = v[0];
    p.intensity_b = v[1];
    p.intensity_c = v[2];
    p.intensity_d = v[3];
    return p;
  endfunction

  initial begin
    item_t px;
    int phase_idle [4] = '{0, 69, 0, 10};
    count_q = 3'd1;
    for (int k = 0; k < 4; k++) coef_q[k] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset configuration, then extremes and special cases.
    px = '1;
    queue_pixel(px);
    drain();
    write_reg(CFG_COUNT, 3'd0);
    write_reg(CFG_COEF0, {16'hFFFF, 16'hFFFF, 16'hFFFF});
    write_reg(CFG_COEF1, {16'hFFFF, 16'hFFFF, 16'h0000});
    write_reg(CFG_COEF2, {16'h0001, 16'h8000, 16'h8000});
    write_reg(CFG_COEF3, {16'h0000, 16'h0000, 16'h0001});
    queue_pixel('1);
    queue_pixel('0);
    drain();
    for (int c = 2; c <= 7; c++) begin
      write_reg(CFG_COUNT, 3'(c));
      queue_pixel('1);
      queue_pixel('0);
      queue_pixel({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
      drain();
    end
    write_reg(CFG_COEF1, {16'hFFFF, 16'hFFFF, 16'hFFFF});
    write_reg(CFG_COEF2, {16'hFFFF, 16'hFFFF, 16'hFFFF});
    write_reg(CFG_COEF3, {16'hFFFF, 16'hFFFF, 16'hFFFF});
    queue_pixel('1);
    queue_pixel({16'h8000, 16'h8000, 16'h8000, 16'h8000});
    drain();

    // Random phases, each with a fresh configuration.
    for (int ph = 0; ph < 20; ph++) begin
      idle_pct = phase_idle[ph % 4];
      write_reg(CFG_COUNT, 3'($urandom_range(7)));
      for (int k = 0; k < 4; k++)
        write_reg(cfg_idx_e'(CFG_COEF0 + k), rnd_coef(ph == 0 ? 0 : $urandom_range(1, 2)));
      for (int i = 0; i < 50; i++)
        queue_pixel(($urandom_range(3) == 0) ? rnd_pixel() : ratio_pixel());
      drain();
    end

    $display("Covered %0d pixels and %0d checked results over 20 random configurations",
             pixels_sent, checked);
    $display("with element counts 0 to 7 and extreme coefficients.");
    if (errors == 0 && compound_q.size() == 0) begin
      $display("compound_from_element_ratios_unit test passed");
    end else begin
      $display("compound_from_element_ratios_unit test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/crx_pkg.sv
rtl/core/crx_weight.sv
rtl/core/crx_step.sv
rtl/core/crx_reduce.sv
rtl/core/compound_from_element_ratios_unit.sv
verif/compound_from_element_ratios_unit_tb.sv
